>>> sv/rha_pkg.sv
package rha_pkg;

  localparam int CMD_W    = 3;
  localparam int HANDLE_W = 6;
  localparam int KIND_W   = 3;
  localparam int OWNER_W  = 8;
  localparam int COUNT_W  = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 3'd0,
    CMD_REF     = 3'd1,
    CMD_UNREF   = 3'd2,
    CMD_LOOKUP  = 3'd3,
    CMD_CLEANUP = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_BAD   = 3'd1,
    STAT_COUNT = 3'd2,
    STAT_OWNER = 3'd3,
    STAT_FULL  = 3'd4,
    STAT_OVF   = 3'd5,
    STAT_NONE  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SCAN_END
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
    logic                released;
    logic [KIND_W-1:0]   kind;
    logic [OWNER_W-1:0]  owner;
    logic                valid;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } res_t;

  localparam res_t RES_NONE = '{
    status:   STAT_NONE,
    handle:   '0,
    released: 1'b0,
    kind:     '0,
    owner:    '0,
    valid:    1'b0,
    count:    '0,
    last:     1'b1
  };

endpackage

>>> sv/rha_cmd_if.sv
interface rha_cmd_if import rha_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [HANDLE_W-1:0] handle;
  logic                drop_owner;
  logic [OWNER_W-1:0]  owner_tag;
  logic [KIND_W-1:0]   obj_kind;

  modport source (output valid, cmd, handle, drop_owner, owner_tag, obj_kind, input ready);
  modport sink (input valid, cmd, handle, drop_owner, owner_tag, obj_kind, output ready);
endinterface

>>> sv/rha_res_if.sv
interface rha_res_if import rha_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic [HANDLE_W-1:0] handle_out;
  logic                released;
  logic [KIND_W-1:0]   kind_out;
  logic [OWNER_W-1:0]  owner_out;
  logic                valid_res;
  logic [COUNT_W-1:0]  count_out;
  logic                last;

  modport source (output valid, status, handle_out, released, kind_out, owner_out, valid_res,
                  count_out, last, input ready);
  modport sink (input valid, status, handle_out, released, kind_out, owner_out, valid_res,
                count_out, last, output ready);
endinterface

>>> sv/rha_ram.sv
module rha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/rha_res_stage.sv
module rha_res_stage import rha_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t din,
  output logic free,
  rha_res_if.source out_if
);

  logic valid_r;
  logic valid_nxt;
  res_t data_r;

  assign free = !valid_r || out_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

  assign out_if.valid      = valid_r;
  assign out_if.status     = data_r.status;
  assign out_if.handle_out = data_r.handle;
  assign out_if.released   = data_r.released;
  assign out_if.kind_out   = data_r.kind;
  assign out_if.owner_out  = data_r.owner;
  assign out_if.valid_res  = data_r.valid;
  assign out_if.count_out  = data_r.count;
  assign out_if.last       = data_r.last;

endmodule

>>> sv/refcounted_handle_allocator.sv
// Alloc, ref, unref and lookup read the table entry from the synchronous RAM in the accept
// cycle, then update it and register it as a result once the result register is free; only
// the idle state accepts a command, so none is taken before the last result is loaded. Owner
// cleanup reads one entry per cycle up to the fresh mark unless the result register stalls
// it, then ends in a closing state. Synchronous active-low reset empties the free list, clears
// the fresh mark and the live bits and leaves the RAM uncleared, so no clearing pass follows reset.
module refcounted_handle_allocator import rha_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int COUNT_BITS  = 16,
  parameter int OWNER_BITS  = 8
) (
  input  logic clk,
  input  logic rst_n,
  rha_cmd_if.sink   in_if,
  rha_res_if.source out_if
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int PTR_W = IDX_W + 1;
  localparam int ENT_W = COUNT_BITS + 1 + OWNER_BITS + KIND_W + PTR_W;
  localparam logic [PTR_W-1:0]      DEPTH_P = PTR_W'(TABLE_DEPTH);
  localparam logic [HANDLE_W:0]     HDL_LIM = (HANDLE_W + 1)'(TABLE_DEPTH);
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CNT_NEW = COUNT_BITS'(2);

  state_t state_r, state_nxt;

  logic [CMD_W-1:0]      cmd_r;
  logic [HANDLE_W-1:0]   hdl_r;
  logic                  hok_r;
  logic                  own_r;
  logic [OWNER_BITS-1:0] tag_r;
  logic [KIND_W-1:0]     kind_r;
  logic [IDX_W-1:0]      slot_r;

  logic [IDX_W-1:0]       scan_r, scan_nxt;
  logic [PTR_W-1:0]       free_head_r, free_head_nxt;
  logic [PTR_W-1:0]       fresh_r, fresh_nxt;
  logic [TABLE_DEPTH-1:0] live_r, live_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  res_t                   pend_r, pend_nxt;
  res_t                   pend_fin;

  logic             in_acc;
  logic             res_load;
  logic             res_free;
  res_t             res_d;

  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  logic [ENT_W-1:0] mem_rd_data;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wr_addr;
  logic [ENT_W-1:0] mem_wr_data;

  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  rd_held;
  logic [OWNER_BITS-1:0] rd_own;
  logic [KIND_W-1:0]     rd_kind;
  logic [PTR_W-1:0]      rd_link;

  logic                  drop_own;
  logic [COUNT_BITS-1:0] drop_cnt_m1;
  status_t               drop_st;
  logic                  drop_rel;
  logic                  drop_wr;
  logic [COUNT_BITS-1:0] drop_cnt;
  logic                  drop_held;

  logic                  exe_valid;
  res_t                  exe_res;
  logic                  exe_we;
  logic [IDX_W-1:0]      exe_addr;
  logic [COUNT_BITS-1:0] exe_cnt;
  logic                  exe_held;
  logic [OWNER_BITS-1:0] exe_own;
  logic [KIND_W-1:0]     exe_kind;
  logic [PTR_W-1:0]      exe_link;
  logic                  exe_set;
  logic                  exe_clr;
  logic [PTR_W-1:0]      exe_fh;
  logic [PTR_W-1:0]      exe_fresh;

  logic scn_match;
  res_t scn_res;
  logic scan_stall;
  logic scan_more;

  rha_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  rha_res_stage u_res (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (res_load),
    .din    (res_d),
    .free   (res_free),
    .out_if (out_if)
  );

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;

  assign {rd_cnt, rd_held, rd_own, rd_kind, rd_link} = mem_rd_data;

  // Dropping one reference is shared by unref and the cleanup walk.
  assign drop_own    = (state_r == ST_SCAN) ? 1'b1 : own_r;
  assign drop_cnt_m1 = rd_cnt - CNT_ONE;

  always_comb begin
    drop_st   = STAT_OK;
    drop_rel  = 1'b0;
    drop_wr   = 1'b0;
    drop_cnt  = rd_cnt;
    drop_held = rd_held;
    if (rd_cnt == CNT_ONE) begin
      drop_st = STAT_COUNT;
    end else if (drop_own && !rd_held) begin
      drop_st = STAT_OWNER;
    end else begin
      drop_wr   = 1'b1;
      drop_held = drop_own ? 1'b0 : rd_held;
      drop_cnt  = drop_cnt_m1;
      if (drop_cnt_m1 == CNT_ONE) begin
        drop_rel = 1'b1;
        drop_cnt = '0;
      end
    end
  end

  assign exe_valid = hok_r && live_r[slot_r];

  always_comb begin
    exe_res   = RES_NONE;
    exe_we    = 1'b0;
    exe_addr  = slot_r;
    exe_cnt   = rd_cnt;
    exe_held  = rd_held;
    exe_own   = rd_own;
    exe_kind  = rd_kind;
    exe_link  = rd_link;
    exe_set   = 1'b0;
    exe_clr   = 1'b0;
    exe_fh    = free_head_r;
    exe_fresh = fresh_r;
    case (cmd_r)
      CMD_ALLOC: begin
        if (free_head_r < DEPTH_P) begin
          exe_addr = free_head_r[IDX_W-1:0];
          exe_fh   = rd_link;
          exe_we   = 1'b1;
        end else if (fresh_r < DEPTH_P) begin
          exe_addr  = fresh_r[IDX_W-1:0];
          exe_fresh = fresh_r + PTR_W'(1);
          exe_we    = 1'b1;
        end else begin
          exe_res.status = STAT_FULL;
        end
        if (exe_we) begin
          exe_cnt  = CNT_NEW;
          exe_held = 1'b1;
          exe_own  = tag_r;
          exe_kind = kind_r;
          exe_set  = 1'b1;
          exe_res  = '{STAT_OK, HANDLE_W'(exe_addr), 1'b0, kind_r, OWNER_W'(tag_r), 1'b1,
                       COUNT_W'(CNT_NEW), 1'b1};
        end
      end
      CMD_REF: begin
        if (!exe_valid) begin
          exe_res = '{STAT_BAD, hdl_r, 1'b0, '0, '0, 1'b0, '0, 1'b1};
        end else if (&rd_cnt) begin
          exe_res = '{STAT_OVF, hdl_r, 1'b0, rd_kind, OWNER_W'(rd_own), 1'b1,
                      COUNT_W'(rd_cnt), 1'b1};
        end else begin
          exe_we  = 1'b1;
          exe_cnt = rd_cnt + CNT_ONE;
          exe_res = '{STAT_OK, hdl_r, 1'b0, rd_kind, OWNER_W'(rd_own), 1'b1,
                      COUNT_W'(exe_cnt), 1'b1};
        end
      end
      CMD_UNREF: begin
        if (!exe_valid) begin
          exe_res = '{STAT_BAD, hdl_r, 1'b0, '0, '0, 1'b0, '0, 1'b1};
        end else begin
          exe_we   = drop_wr;
          exe_cnt  = drop_cnt;
          exe_held = drop_held;
          if (drop_rel) begin
            exe_link = free_head_r;
            exe_fh   = {1'b0, slot_r};
            exe_clr  = 1'b1;
          end
          exe_res = '{drop_st, hdl_r, drop_rel, rd_kind, OWNER_W'(rd_own), !drop_rel,
                      COUNT_W'(drop_cnt), 1'b1};
        end
      end
      CMD_LOOKUP: begin
        if (!exe_valid) begin
          exe_res = '{STAT_BAD, hdl_r, 1'b0, '0, '0, 1'b0, '0, 1'b1};
        end else begin
          exe_res = '{STAT_OK, hdl_r, 1'b0, rd_kind, OWNER_W'(rd_own), 1'b1,
                      COUNT_W'(rd_cnt), 1'b1};
        end
      end
      default: begin
        exe_res = RES_NONE;
      end
    endcase
  end

  // Root entries carry tag zero and are never matched by the walk.
  assign scn_match  = live_r[scan_r] && (rd_own != '0) && rd_held && (rd_own == tag_r);
  assign scn_res    = '{drop_st, HANDLE_W'(scan_r), drop_rel, rd_kind, OWNER_W'(rd_own),
                        !drop_rel, COUNT_W'(drop_cnt), 1'b0};
  assign scan_stall = scn_match && pend_vld_r && !res_free;
  assign scan_more  = (PTR_W'({1'b0, scan_r}) + PTR_W'(1)) < fresh_r;

  always_comb begin
    pend_fin      = pend_r;
    pend_fin.last = 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_if.cmd == CMD_CLEANUP) begin
            state_nxt = (fresh_r == '0) ? ST_SCAN_END : ST_SCAN;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (res_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!scan_stall && !scan_more) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        if (res_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;
    mem_we        = 1'b0;
    mem_wr_addr   = exe_addr;
    mem_wr_data   = {exe_cnt, exe_held, exe_own, exe_kind, exe_link};
    res_load      = 1'b0;
    res_d         = exe_res;
    free_head_nxt = free_head_r;
    fresh_nxt     = fresh_r;
    live_nxt      = live_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    pend_vld_nxt  = pend_vld_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mem_rd_en    = 1'b1;
          scan_nxt     = '0;
          pend_vld_nxt = 1'b0;
          if ((in_if.cmd == CMD_ALLOC) && (free_head_r < DEPTH_P)) begin
            mem_rd_addr = free_head_r[IDX_W-1:0];
          end else if (in_if.cmd == CMD_CLEANUP) begin
            mem_rd_addr = '0;
          end else begin
            mem_rd_addr = in_if.handle[IDX_W-1:0];
          end
        end
      end
      ST_EXEC: begin
        if (res_free) begin
          res_load      = 1'b1;
          res_d         = exe_res;
          mem_we        = exe_we;
          free_head_nxt = exe_fh;
          fresh_nxt     = exe_fresh;
          if (exe_set) begin
            live_nxt[exe_addr] = 1'b1;
          end
          if (exe_clr) begin
            live_nxt[exe_addr] = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (!scan_stall) begin
          if (scn_match) begin
            mem_we      = drop_wr;
            mem_wr_addr = scan_r;
            mem_wr_data = {drop_cnt, drop_held, rd_own, rd_kind,
                           drop_rel ? free_head_r : rd_link};
            if (drop_rel) begin
              free_head_nxt    = {1'b0, scan_r};
              live_nxt[scan_r] = 1'b0;
            end
            if (pend_vld_r) begin
              res_load = 1'b1;
              res_d    = pend_r;
            end
            pend_nxt     = scn_res;
            pend_vld_nxt = 1'b1;
          end
          if (scan_more) begin
            scan_nxt    = scan_r + IDX_W'(1);
            mem_rd_en   = 1'b1;
            mem_rd_addr = scan_r + IDX_W'(1);
          end
        end
      end
      ST_SCAN_END: begin
        if (res_free) begin
          res_load     = 1'b1;
          res_d        = pend_vld_r ? pend_fin : RES_NONE;
          pend_vld_nxt = 1'b0;
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_head_r <= DEPTH_P;
      fresh_r     <= '0;
      live_r      <= '0;
      scan_r      <= '0;
      pend_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      fresh_r     <= fresh_nxt;
      live_r      <= live_nxt;
      scan_r      <= scan_nxt;
      pend_vld_r  <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (in_acc) begin
      cmd_r  <= in_if.cmd;
      hdl_r  <= in_if.handle;
      hok_r  <= ({1'b0, in_if.handle} < HDL_LIM);
      own_r  <= in_if.drop_owner;
      tag_r  <= OWNER_BITS'(in_if.owner_tag);
      kind_r <= in_if.obj_kind;
      slot_r <= in_if.handle[IDX_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= DEPTH_P)
    else $error("free list head beyond the table");

  a_fresh_range: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= DEPTH_P)
    else $error("fresh mark beyond the table");

  a_head_not_live: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r < DEPTH_P) |-> !live_r[free_head_r[IDX_W-1:0]])
    else $error("free list head is a live entry");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> res_free)
    else $error("result register overwritten before its transaction");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (PTR_W'({1'b0, scan_r}) < fresh_r))
    else $error("cleanup walk beyond the fresh mark");
`endif

endmodule
